// ===== sv/okm_pkg.sv =====
// Package for the online k-means cluster update unit.
// Holds shared constants, action codes and the divider control struct.
// No dependencies.
`timescale 1ns / 1ps
package okm_pkg;
    localparam int CLUSTERS_DEF     = 8;
    localparam int FEATURES_DEF     = 4;
    localparam int FEATURE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF   = 24;
    localparam int DIST_BITS        = 34;
    localparam int NC_BITS          = 4;
    localparam int NF_BITS          = 3;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_LEARN = 2'd1;

    localparam logic CFG_NUM_CLUSTERS = 1'b0;
    localparam logic CFG_NUM_FEATURES = 1'b1;

    // divider control word
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// ===== sv/okm_div.sv =====
// Restoring serial divider: signed dividend by unsigned divisor, one quotient bit a cycle.
// Quotient truncated toward zero. Depends on okm_pkg.
`timescale 1ns / 1ps
module okm_div #(
    parameter int NUM_BITS = 17,
    parameter int DEN_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic        [DEN_BITS-1:0] i_den,
    output okm_pkg::t_div_ctl          o_ctl,
    output logic signed [NUM_BITS-1:0] o_quot
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_q, n_q;
    logic [DEN_BITS-1:0] r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic                r_neg, r_busy, r_done;
    logic [CW-1:0]       r_cnt;
    logic [DEN_BITS:0]   w_trial;
    logic [NUM_BITS-1:0] w_mag;

    assign w_mag   = i_num[NUM_BITS-1] ? (~i_num + 1'b1) : i_num;
    assign w_trial = {r_rem, r_q[NUM_BITS-1]};

    // one shift and trial subtract per cycle
    always_comb begin
        n_q   = {r_q[NUM_BITS-2:0], 1'b0};
        n_rem = w_trial[DEN_BITS-1:0];
        if (w_trial >= {1'b0, r_den}) begin
            n_rem  = DEN_BITS'(w_trial - {1'b0, r_den});
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_BITS-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quot = r_neg ? (~r_q + 1'b1) : r_q;

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_done && r_den != '0) begin
            assert (r_q <= (r_neg ? NUM_BITS'(1) << (NUM_BITS-1) : {NUM_BITS{1'b1}}))
                else $error("quotient magnitude out of range");
        end
    end
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done) else $error("busy and done together");
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
endmodule

// ===== sv/online_kmeans_cluster_update_unit.sv =====
// Top level of the online k-means cluster update unit: sequencer, shared
// multiply-accumulate unit, centroid and count registers. Uses okm_pkg and okm_div.
// Sequence: load writes the slot and goes straight to the output step; learn/classify
// computes one square per cycle through the shared multiplier, then one compare per
// centroid; learn then runs the serial divider for each feature (issue, start,
// FEATURE_BITS+1 quotient bits, write-back). A not-ready refusal goes to the output step.
// One item at a time; busy high meanwhile. Results are strobed one cycle; the
// receiver cannot stall.
// Synchronous active-low reset clears table, counts and model_ready, and sets config to 8 clusters, 4 features.
`timescale 1ns / 1ps
module online_kmeans_cluster_update_unit #(
    parameter int CLUSTERS     = okm_pkg::CLUSTERS_DEF,
    parameter int FEATURES     = okm_pkg::FEATURES_DEF,
    parameter int FEATURE_BITS = okm_pkg::FEATURE_BITS_DEF,
    parameter int COUNT_BITS   = okm_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [okm_pkg::NC_BITS-1:0]    i_cfg_data,
    input  logic [1:0]                     i_action,
    input  logic [2:0]                     i_cluster_index,
    input  logic [COUNT_BITS-1:0]          i_load_count,
    input  logic signed [FEATURE_BITS-1:0] i_feature_0,
    input  logic signed [FEATURE_BITS-1:0] i_feature_1,
    input  logic signed [FEATURE_BITS-1:0] i_feature_2,
    input  logic signed [FEATURE_BITS-1:0] i_feature_3,
    output logic                           o_valid,
    output logic                           o_status,
    output logic [2:0]                     o_cluster,
    output logic [okm_pkg::DIST_BITS-1:0]  o_squared_distance
);
    localparam int CI = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int FI = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int DB = FEATURE_BITS + 1;
    localparam int AB = 2 * DB + FI + 1;
    localparam int DW = okm_pkg::DIST_BITS;
    localparam int IN_F = (FEATURES < 4) ? FEATURES : 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIST = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [okm_pkg::NC_BITS-1:0] r_nc_reg;
    logic [okm_pkg::NF_BITS-1:0] r_nf_reg;
    logic signed [FEATURE_BITS-1:0] r_cent [CLUSTERS][FEATURES];
    logic [COUNT_BITS-1:0] r_cnt [CLUSTERS];
    logic r_ready;
    logic signed [FEATURE_BITS-1:0] r_pt [FEATURES];
    logic [1:0] r_act;
    logic [CI-1:0] r_c, r_best;
    logic [FI-1:0] r_f;
    logic [AB-1:0] r_acc;
    logic [AB-1:0] r_best_d;
    logic r_first;
    logic [CI:0] w_nc;
    logic [FI:0] w_nf;
    logic signed [DB-1:0] w_diff;
    logic [DB-1:0] w_mag;
    logic [2*DB-1:0] w_sq;
    logic [COUNT_BITS-1:0] w_newcnt;
    okm_pkg::t_div_ctl w_div;
    logic signed [DB-1:0] w_quot;
    logic r_dstart;
    logic r_status;
    logic [2:0] r_oc;
    logic [DW-1:0] r_od;
    logic r_ov;
    logic signed [FEATURE_BITS-1:0] w_in [4];

    assign w_in[0] = i_feature_0;
    assign w_in[1] = i_feature_1;
    assign w_in[2] = i_feature_2;
    assign w_in[3] = i_feature_3;

    // clamp configuration to between one and the built size
    always_comb begin
        if (r_nc_reg == '0) w_nc = (CI+1)'(1);
        else if (32'(r_nc_reg) > CLUSTERS) w_nc = (CI+1)'(CLUSTERS);
        else w_nc = (CI+1)'(r_nc_reg);
        if (r_nf_reg == '0) w_nf = (FI+1)'(1);
        else if (32'(r_nf_reg) > FEATURES) w_nf = (FI+1)'(FEATURES);
        else w_nf = (FI+1)'(r_nf_reg);
    end

    // shared difference and square unit
    assign w_diff = DB'(r_pt[r_f]) - DB'(r_cent[(r_state == S_DIST) ? r_c : r_best][r_f]);
    assign w_mag  = w_diff[DB-1] ? DB'(-w_diff) : DB'(w_diff);
    assign w_sq   = (2*DB)'(w_mag) * (2*DB)'(w_mag);
    assign w_newcnt = (&r_cnt[r_best]) ? r_cnt[r_best] : r_cnt[r_best] + 1'b1;

    okm_div #(.NUM_BITS(DB), .DEN_BITS(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (w_diff),
        .i_den   (r_cnt[r_best]),
        .o_ctl   (w_div),
        .o_quot  (w_quot)
    );

    assign busy = (r_state != S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc_reg <= okm_pkg::NC_BITS'(8);
            r_nf_reg <= okm_pkg::NF_BITS'(4);
        end else if (i_cfg_we) begin
            if (i_cfg_index == okm_pkg::CFG_NUM_CLUSTERS) r_nc_reg <= i_cfg_data;
            else r_nf_reg <= i_cfg_data[okm_pkg::NF_BITS-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b0;
            r_ov     <= 1'b0;
            r_dstart <= 1'b0;
            for (int c = 0; c < CLUSTERS; c++) begin
                r_cnt[c] <= '0;
                for (int f = 0; f < FEATURES; f++) r_cent[c][f] <= '0;
            end
        end else begin
            r_ov     <= 1'b0;
            r_dstart <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_act <= i_action;
                        for (int f = 0; f < FEATURES; f++)
                            r_pt[f] <= (f < IN_F) ? w_in[f] : '0;
                        r_c <= '0; r_f <= '0; r_acc <= '0; r_first <= 1'b1;
                        r_best <= '0; r_best_d <= '0;
                        if (i_action == okm_pkg::ACT_LOAD) begin
                            if (32'(i_cluster_index) < CLUSTERS) begin
                                for (int f = 0; f < FEATURES; f++)
                                    if (f < IN_F)
                                        r_cent[CI'(i_cluster_index)][f] <= w_in[f];
                                r_cnt[CI'(i_cluster_index)] <= i_load_count;
                            end
                            r_ready  <= 1'b1;
                            r_status <= 1'b0;
                            r_oc     <= i_cluster_index;
                            r_od     <= '0;
                            r_state  <= S_OUT;
                        end else if (!r_ready) begin
                            r_status <= 1'b1;
                            r_oc     <= '0;
                            r_od     <= '0;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_DIST: begin
                    if ((FI+1)'(r_f) + 1'b1 == w_nf) begin
                        r_acc   <= r_acc + AB'(w_sq);
                        r_f     <= '0;
                        r_state <= S_CMP;
                    end else begin
                        r_acc <= r_acc + AB'(w_sq);
                        r_f   <= r_f + 1'b1;
                    end
                end
                S_CMP: begin
                    // strict less keeps the lowest index on ties
                    if (r_first || r_acc < r_best_d) begin
                        r_best_d <= r_acc;
                        r_best   <= r_c;
                    end
                    r_first <= 1'b0;
                    r_acc   <= '0;
                    if ((CI+1)'(r_c) + 1'b1 == w_nc) begin
                        r_state <= (r_act == okm_pkg::ACT_LEARN) ? S_DIVS : S_OUT;
                        r_status <= 1'b0;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_DIST;
                    end
                end
                S_DIVS: begin
                    if (r_f == '0) r_cnt[r_best] <= w_newcnt;
                    r_dstart <= 1'b1;
                    r_state  <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_div.done) begin
                        r_cent[r_best][r_f] <= r_cent[r_best][r_f] + FEATURE_BITS'(w_quot);
                        if ((FI+1)'(r_f) + 1'b1 == w_nf) begin
                            r_state <= S_OUT;
                        end else begin
                            r_f     <= r_f + 1'b1;
                            r_state <= S_DIVS;
                        end
                    end
                end
                S_OUT: begin
                    if (r_act != okm_pkg::ACT_LOAD && !r_status) begin
                        r_oc <= 3'(r_best);
                        r_od <= DW'(r_best_d);
                    end
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_ov;
    assign o_status           = r_status;
    assign o_cluster          = r_oc;
    assign o_squared_distance = r_od;

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |=> !r_ov) else $error("result strobe held");
    a_strobe_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> $past(r_state) == S_OUT) else $error("strobe outside output step");
    a_refuse_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_status) |-> (r_oc == '0 && r_od == '0)) else $error("refusal payload");
    a_div_only_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dstart |-> r_act == okm_pkg::ACT_LEARN) else $error("divide outside learn");
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the online k-means cluster update unit.
// Predicts every result word in-bench; depends on okm_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_top;
    localparam int NCL = 8;
    localparam int NFE = 4;
    localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
    localparam int WDOG_LIMIT = 20000;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;
    localparam logic [1:0] ACT_SPARE    = 2'd3;

    typedef struct packed {
        logic        status;
        logic [2:0]  cluster;
        logic [33:0] sqd;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [3:0]  i_cfg_data = '0;
    logic [1:0]  i_action = '0;
    logic [2:0]  i_cluster_index = '0;
    logic [23:0] i_load_count = '0;
    logic signed [15:0] i_feature_0 = '0, i_feature_1 = '0, i_feature_2 = '0, i_feature_3 = '0;
    logic        o_valid;
    logic        o_status;
    logic [2:0]  o_cluster;
    logic [33:0] o_squared_distance;

    online_kmeans_cluster_update_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    longint      cent [NCL][NFE];
    logic [23:0] cnt [NCL];
    bit          ready;
    logic [3:0]  nclu;
    logic [2:0]  nfeat;
    t_res        pending_res[$];
    int          errors = 0;
    int          n_items = 0;
    int          n_res = 0;
    int          idle_cycles = 0;
    bit          gappy = 1'b1;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_res);
    endtask

    // load, not-ready refusal, nearest-centroid search plus learn update
    function automatic t_res cluster_step(input logic [1:0] act, input logic [2:0] slot,
                                          input logic [23:0] lc, input longint p [NFE]);
        t_res r;
        int nc, nf, best;
        longint d, bd, df;
        r = '0;
        if (act == okm_pkg::ACT_LOAD) begin
            for (int j = 0; j < NFE; j++) cent[slot][j] = p[j];
            cnt[slot] = lc;
            ready = 1'b1;
            r.cluster = slot;
            return r;
        end
        if (!ready) begin
            r.status = 1'b1;
            return r;
        end
        nc = (nclu < 1) ? 1 : (nclu > NCL) ? NCL : nclu;
        nf = (nfeat < 1) ? 1 : (nfeat > NFE) ? NFE : nfeat;
        best = 0;
        bd = -1;
        for (int c = 0; c < nc; c++) begin
            d = 0;
            for (int j = 0; j < nf; j++) d += (p[j] - cent[c][j]) * (p[j] - cent[c][j]);
            if (bd < 0 || d < bd) begin
                bd = d;
                best = c;
            end
        end
        if (act == okm_pkg::ACT_LEARN) begin
            if (cnt[best] != CNT_MAX) cnt[best]++;
            for (int j = 0; j < nf; j++) begin
                df = p[j] - cent[best][j];
                cent[best][j] += df / longint'(cnt[best]);
            end
        end
        r.cluster = best[2:0];
        r.sqd = bd[33:0];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_valid) begin
            n_res++;
            if (pending_res.size() == 0) begin
                report("unexpected result word", 1, 0);
            end else begin
                w = pending_res.pop_front();
                if (o_status !== w.status) report("status", o_status, w.status);
                if (o_cluster !== w.cluster) report("cluster", o_cluster, w.cluster);
                if (o_squared_distance !== w.sqd)
                    report("squared_distance", o_squared_distance, w.sqd);
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // send one word and record its prediction; start stays high until the next
    // idle gap or drain
    task automatic send_word(input logic [1:0] act, input logic [2:0] slot,
                             input logic [23:0] lc, input logic [15:0] f0,
                             input logic [15:0] f1, input logic [15:0] f2,
                             input logic [15:0] f3);
        longint p [NFE];
        while (gappy && $urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_cluster_index <= slot;
        i_load_count <= lc;
        i_feature_0 <= f0;
        i_feature_1 <= f1;
        i_feature_2 <= f2;
        i_feature_3 <= f3;
        // busy as seen before the edge decides acceptance
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p[0] = longint'($signed(f0));
        p[1] = longint'($signed(f1));
        p[2] = longint'($signed(f2));
        p[3] = longint'($signed(f3));
        pending_res.push_back(cluster_step(act, slot, lc, p));
        n_items++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input logic idx, input logic [3:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == okm_pkg::CFG_NUM_CLUSTERS) nclu = val;
        else nfeat = val[2:0];
    endtask

    function automatic logic [15:0] rnd_feat(input int spread);
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic test_not_ready;
        send_word(okm_pkg::ACT_LEARN, 3'd0, 24'd0, 16'h7FFF, 16'h8000, 16'd1, 16'hFFFF);
        send_word(ACT_CLASSIFY, 3'd5, 24'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_word(ACT_SPARE, 3'd7, 24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    endtask

    task automatic test_directed;
        send_word(okm_pkg::ACT_LOAD, 3'd0, 24'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_word(ACT_CLASSIFY, 3'd0, 24'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(okm_pkg::ACT_LOAD, 3'd7, CNT_MAX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(okm_pkg::ACT_LOAD, 3'd3, CNT_MAX - 1, 16'd100, 16'd100, 16'd100, 16'd100);
        // count saturation: two learns on the same slot
        send_word(okm_pkg::ACT_LEARN, 3'd0, 24'd0, 16'd120, 16'd80, 16'd100, 16'd100);
        send_word(okm_pkg::ACT_LEARN, 3'd0, 24'd0, 16'd5000, 16'd100, 16'd100, 16'd100);
        // tie: point at equal distance from slots 1 and 2 (both empty = zero)
        send_word(ACT_CLASSIFY, 3'd0, 24'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_word(okm_pkg::ACT_LEARN, 3'd0, 24'd0, 16'hFFF9, 16'd3, 16'd0, 16'd0);
        send_word(okm_pkg::ACT_LOAD, 3'd4, 24'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_word(ACT_SPARE, 3'd2, 24'd9, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_word(okm_pkg::ACT_LEARN, 3'd1, 24'd3, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_registers;
        write_reg(okm_pkg::CFG_NUM_CLUSTERS, 4'd0);
        write_reg(okm_pkg::CFG_NUM_FEATURES, 4'd0);
        send_word(okm_pkg::ACT_LEARN, 3'd0, 24'd0, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0);
        write_reg(okm_pkg::CFG_NUM_CLUSTERS, 4'd15);
        write_reg(okm_pkg::CFG_NUM_FEATURES, 4'd7);
        send_word(ACT_CLASSIFY, 3'd0, 24'd0, 16'h8000, 16'd0, 16'h7FFF, 16'd0);
        write_reg(okm_pkg::CFG_NUM_CLUSTERS, 4'd8);
        write_reg(okm_pkg::CFG_NUM_FEATURES, 4'd4);
    endtask

    // mostly learn/classify around loaded centroids, with reloads as noise
    task automatic test_random(input int n);
        logic [1:0] act;
        int sp;
        for (int i = 0; i < n; i++) begin
            gappy = !(i >= n / 3 && i < n / 2);
            sp = ($urandom_range(0, 3) == 0) ? 32768 : 2000;
            case ($urandom_range(0, 9))
                0, 1: act = okm_pkg::ACT_LOAD;
                2, 3, 4, 5: act = okm_pkg::ACT_LEARN;
                6, 7, 8: act = ACT_CLASSIFY;
                default: act = ACT_SPARE;
            endcase
            send_word(act, 3'($urandom), ($urandom_range(0, 4) == 0) ? 24'($urandom) :
                      24'($urandom_range(0, 40)), rnd_feat(sp), rnd_feat(sp),
                      rnd_feat(sp), rnd_feat(sp));
        end
        gappy = 1'b1;
    endtask

    task automatic test_settings;
        for (int k = 0; k < 6; k++) begin
            write_reg(okm_pkg::CFG_NUM_CLUSTERS, 4'($urandom_range(0, 9)));
            write_reg(okm_pkg::CFG_NUM_FEATURES, 4'($urandom_range(0, 5)));
            test_random(200);
        end
    endtask

    initial begin
        for (int c = 0; c < NCL; c++) begin
            cnt[c] = '0;
            for (int j = 0; j < NFE; j++) cent[c][j] = 0;
        end
        ready = 1'b0;
        nclu = 4'd8;
        nfeat = 3'd4;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_not_ready();
        test_directed();
        test_registers();
        test_random(450);
        test_settings();
        drain();
        $display("covered %0d input words and %0d result words", n_items, n_res);
        $display("register sweeps included out-of-range cluster and feature counts");
        if (errors == 0 && pending_res.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
